@@ hw/rtl/salru_pkg.sv @@
// shared types and constants of the set associative cache lru tracker
package salru_pkg;

   // access kinds
   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_STORE  = 2'd1;
   localparam logic [1:0] CMD_MODIFY = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_INDEX_BITS  = 2'd0;
   localparam logic [1:0] CSR_OFFSET_BITS = 2'd1;
   localparam logic [1:0] CSR_WAYS_IN_USE = 2'd2;

   // configuration reset values
   localparam logic [2:0] INDEX_BITS_RST  = 3'd4;
   localparam logic [5:0] OFFSET_BITS_RST = 6'd4;
   localparam logic [3:0] WAYS_IN_USE_RST = 4'd8;

   // widest configuration register
   localparam int CSR_DATA_W = 6;

   // counter saturation value
   localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

   // sequencer states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   // request beat
   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] address;
   } req_type;

   // result beat
   typedef struct packed {
      logic        was_hit;
      logic        was_miss;
      logic        was_eviction;
      logic        modify_hit;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
      logic [31:0] eviction_total;
   } rsp_type;

   // outcome of one set lookup
   typedef struct packed {
      logic hit;
      logic miss;
      logic evict;
   } lookup_type;

endpackage

@@ hw/rtl/salru_set_ram.sv @@
// one row per set memory with registered read data
module salru_set_ram #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6,
   parameter int WIDTH  = 544
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/salru_way_logic.sv @@
// tag compare, victim choice and rank update over the ways of one set
module salru_way_logic #(
   parameter int WAYS   = 8,
   parameter int TAG_W  = 64,
   parameter int RANK_W = 3
) (
   input  logic [WAYS*(1+TAG_W+RANK_W)-1:0] row_in,
   input  logic [TAG_W-1:0]                 tag,
   input  logic [3:0]                       ways_in_use,
   output logic [WAYS*(1+TAG_W+RANK_W)-1:0] row_out,
   output salru_pkg::lookup_type            result
);
   import salru_pkg::*;

   localparam int WAY_W = 1 + TAG_W + RANK_W;
   localparam int WI_W  = (WAYS > 1) ? $clog2(WAYS) : 1;

   logic [4:0]        ways_eff;
   logic              vld   [WAYS];
   logic [TAG_W-1:0]  tg    [WAYS];
   logic [RANK_W-1:0] rk    [WAYS];
   logic [RANK_W-1:0] rk_old[WAYS];
   logic [WAYS-1:0]   used;
   logic [WAYS-1:0]   match;
   logic              hit;
   logic [WI_W-1:0]   hit_way;
   logic [RANK_W-1:0] hit_rank;
   logic              found_empty;
   logic [WI_W-1:0]   empty_way;
   logic [RANK_W-1:0] best;
   logic [WI_W-1:0]   lru_way;
   logic [WI_W-1:0]   fill_way;

   // clamp the associativity to 1..WAYS
   always_comb begin
      if (ways_in_use == 4'd0) begin
         ways_eff = 5'd1;
      end else if ({1'b0, ways_in_use} > 5'(WAYS)) begin
         ways_eff = 5'(WAYS);
      end else begin
         ways_eff = {1'b0, ways_in_use};
      end
   end

   // unpack the row and compare tags
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         vld[w]    = row_in[w*WAY_W + TAG_W + RANK_W];
         tg[w]     = row_in[w*WAY_W + RANK_W +: TAG_W];
         rk_old[w] = row_in[w*WAY_W +: RANK_W];
         used[w]   = 5'(w) < ways_eff;
         match[w]  = used[w] && vld[w] && (tg[w] == tag);
      end
   end

   // lowest matching way and lowest empty way
   always_comb begin
      hit         = 1'b0;
      hit_way     = '0;
      found_empty = 1'b0;
      empty_way   = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (match[w] && !hit) begin
            hit     = 1'b1;
            hit_way = WI_W'(w);
         end
         if (used[w] && !vld[w] && !found_empty) begin
            found_empty = 1'b1;
            empty_way   = WI_W'(w);
         end
      end
   end

   assign hit_rank = rk_old[hit_way];

   // oldest used way, lowest on a tie
   always_comb begin
      best    = '0;
      lru_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (used[w] && ((w == 0) || (rk_old[w] > best))) begin
            best    = rk_old[w];
            lru_way = WI_W'(w);
         end
      end
   end

   assign fill_way = found_empty ? empty_way : lru_way;

   // new ranks, valid bits and tags
   always_comb begin
      row_out = row_in;
      for (int w = 0; w < WAYS; w++) begin
         rk[w] = rk_old[w];
         if (hit) begin
            if (WI_W'(w) == hit_way) begin
               rk[w] = '0;
            end else if (used[w] && vld[w] && (rk_old[w] < hit_rank)
                         && (rk_old[w] != RANK_W'(WAYS - 1))) begin
               rk[w] = rk_old[w] + 1'b1;
            end
         end else begin
            if (WI_W'(w) == fill_way) begin
               rk[w] = '0;
               row_out[w*WAY_W + TAG_W + RANK_W] = 1'b1;
               row_out[w*WAY_W + RANK_W +: TAG_W] = tag;
            end else if (used[w] && vld[w] && (rk_old[w] != RANK_W'(WAYS - 1))) begin
               rk[w] = rk_old[w] + 1'b1;
            end
         end
         row_out[w*WAY_W +: RANK_W] = rk[w];
      end
   end

   assign result.hit   = hit;
   assign result.miss  = !hit;
   assign result.evict = !hit && !found_empty;

endmodule

@@ hw/rtl/set_assoc_cache_lru_tracker.sv @@
// top level: set associative cache tracker with true lru replacement
//
// Request channel (req_valid, req_stall, req_payload) carries one access:
// a command (load, store, modify) and a byte address. Result channel
// (rsp_valid, rsp_stall, rsp_payload) returns one beat per access with
// hit, miss, eviction and modify flags and the saturating running totals.
// The csr_ port writes the set index width, the block offset width and
// ways_in_use; write it only while no access is in flight.
//
// Each set is one row of a single memory holding valid, tag and lru rank of
// every way. An access reads its row at acceptance, compares and updates it
// in the next cycle and writes it back; no new request is taken until that
// write-back, and the result beat appears in the cycle after the write-back.
// The read-modify-write of the set row is why accesses do not overlap.
// After reset the block sweeps all 2**MAX_SET_BITS rows of the memory to
// clear them, one row per cycle, with req_stall high. When rsp_stall holds a
// result, the next access is still accepted and then waits in its compare
// stage until the result register is free.
module set_assoc_cache_lru_tracker #(
   parameter int MAX_SET_BITS = 6,
   parameter int WAYS         = 8,
   parameter int ADDR_WIDTH   = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  salru_pkg::req_type            req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output salru_pkg::rsp_type            rsp_payload,
   input  logic                          csr_wr_en,
   input  logic [1:0]                    csr_index,
   input  logic [salru_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import salru_pkg::*;

   localparam int NSETS  = 1 << MAX_SET_BITS;
   localparam int IDX_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ROW_W  = WAYS * (1 + ADDR_WIDTH + RANK_W);

   state_type            state_ff, state_in;
   logic [2:0]           index_bits_ff;
   logic [5:0]           offset_bits_ff;
   logic [3:0]           ways_ff;
   logic [IDX_W-1:0]     clr_cnt_ff;
   logic [IDX_W-1:0]     set_ff;
   logic [ADDR_WIDTH-1:0] tag_ff;
   logic [1:0]           cmd_ff;
   logic [31:0]          hit_cnt_ff, hit_cnt_in;
   logic [31:0]          miss_cnt_ff, miss_cnt_in;
   logic [31:0]          evict_cnt_ff, evict_cnt_in;
   logic                 rsp_valid_ff;
   rsp_type              rsp_payload_ff;

   logic                 req_accept;
   logic                 rsp_take;
   logic                 proceed;
   logic                 clr_done;
   logic [3:0]           set_eff;
   logic [6:0]           tag_shift;
   logic [ADDR_WIDTH-1:0] addr_m;
   logic [ADDR_WIDTH-1:0] tag_calc;
   logic [ADDR_WIDTH-1:0] set_full;
   logic [IDX_W:0]       set_mask;
   logic [IDX_W-1:0]     set_calc;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   logic [ROW_W-1:0]     mem_wdata;
   logic [ROW_W-1:0]     row_rd;
   logic [ROW_W-1:0]     row_new;
   lookup_type           lookup;
   logic                 mod_hit;
   logic [1:0]           hit_inc;
   logic [32:0]          hit_sum;
   logic [32:0]          miss_sum;
   logic [32:0]          evict_sum;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         index_bits_ff  <= INDEX_BITS_RST;
         offset_bits_ff <= OFFSET_BITS_RST;
         ways_ff        <= WAYS_IN_USE_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_INDEX_BITS:  index_bits_ff  <= csr_wdata[2:0];
            CSR_OFFSET_BITS: offset_bits_ff <= csr_wdata[5:0];
            CSR_WAYS_IN_USE: ways_ff        <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // address split into tag and set index
   always_comb begin
      set_eff   = ({1'b0, index_bits_ff} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS)
                                                             : {1'b0, index_bits_ff};
      tag_shift = 7'(set_eff) + 7'(offset_bits_ff);
      addr_m    = req_payload.address[ADDR_WIDTH-1:0];
      tag_calc  = addr_m >> tag_shift;
      set_full  = addr_m >> offset_bits_ff;
      set_mask  = ((IDX_W+1)'(1) << set_eff) - 1'b1;
      set_calc  = set_full[IDX_W-1:0] & set_mask[IDX_W-1:0];
   end

   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign clr_done   = (clr_cnt_ff == IDX_W'(NSETS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clr_done) state_in = ST_IDLE;
         ST_IDLE:   if (req_accept) state_in = ST_LOOKUP;
         ST_LOOKUP: if (proceed) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      proceed   = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = clr_cnt_ff;
      mem_wdata = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_LOOKUP: begin
            proceed   = !(rsp_valid_ff && rsp_stall);
            mem_we    = proceed;
            mem_waddr = set_ff;
            mem_wdata = row_new;
         end
         default: ;
      endcase
   end

   // state and clear sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
      end
   end

   // access held for the compare stage
   always_ff @(posedge clock) begin
      if (req_accept) begin
         set_ff <= set_calc;
         tag_ff <= tag_calc;
         cmd_ff <= req_payload.command;
      end
   end

   salru_set_ram #(
      .DEPTH  (NSETS),
      .ADDR_W (IDX_W),
      .WIDTH  (ROW_W)
   ) u_set_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (req_accept),
      .rd_addr (set_calc),
      .rd_data (row_rd)
   );

   salru_way_logic #(
      .WAYS   (WAYS),
      .TAG_W  (ADDR_WIDTH),
      .RANK_W (RANK_W)
   ) u_way_logic (
      .row_in      (row_rd),
      .tag         (tag_ff),
      .ways_in_use (ways_ff),
      .row_out     (row_new),
      .result      (lookup)
   );

   // saturating totals
   always_comb begin
      mod_hit      = (cmd_ff == CMD_MODIFY);
      hit_inc      = 2'(lookup.hit) + 2'(mod_hit);
      hit_sum      = {1'b0, hit_cnt_ff} + 33'(hit_inc);
      miss_sum     = {1'b0, miss_cnt_ff} + 33'(lookup.miss);
      evict_sum    = {1'b0, evict_cnt_ff} + 33'(lookup.evict);
      hit_cnt_in   = hit_sum[32] ? CNT_MAX : hit_sum[31:0];
      miss_cnt_in  = miss_sum[32] ? CNT_MAX : miss_sum[31:0];
      evict_cnt_in = evict_sum[32] ? CNT_MAX : evict_sum[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         evict_cnt_ff <= '0;
      end else if (proceed) begin
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         evict_cnt_ff <= evict_cnt_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (proceed) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proceed) begin
         rsp_payload_ff.was_hit        <= lookup.hit;
         rsp_payload_ff.was_miss       <= lookup.miss;
         rsp_payload_ff.was_eviction   <= lookup.evict;
         rsp_payload_ff.modify_hit     <= mod_hit;
         rsp_payload_ff.hit_total      <= hit_cnt_in;
         rsp_payload_ff.miss_total     <= miss_cnt_in;
         rsp_payload_ff.eviction_total <= evict_cnt_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

@@ test/lru_outcome_pkg.sv @@
// lru cache outcome predictor and result checker for the tracker testbench
`timescale 1ns / 1ps

package lru_outcome_pkg;
   import salru_pkg::*;

   // geometry of the block as instantiated
   localparam int MAX_SETB  = 6;
   localparam int NUM_WAYS  = 8;
   localparam int NUM_LINES = (1 << MAX_SETB) * NUM_WAYS;

   // codes the block has no name for
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   class lru_outcome_tracker;
      bit          line_ok   [NUM_LINES];
      logic [63:0] line_tag  [NUM_LINES];
      logic [2:0]  line_rank [NUM_LINES];
      logic [31:0] hits;
      logic [31:0] misses;
      logic [31:0] evictions;
      logic [2:0]  index_bits;
      logic [5:0]  offset_bits;
      logic [3:0]  ways_cfg;
      rsp_type     outcomes_due[$];
      int          mismatches;

      function new();
         for (int i = 0; i < NUM_LINES; i++) begin
            line_ok[i]   = 1'b0;
            line_tag[i]  = '0;
            line_rank[i] = '0;
         end
         hits        = '0;
         misses      = '0;
         evictions   = '0;
         index_bits  = INDEX_BITS_RST;
         offset_bits = OFFSET_BITS_RST;
         ways_cfg    = WAYS_IN_USE_RST;
         mismatches  = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [5:0] val);
         case (idx)
            CSR_INDEX_BITS:  index_bits  = val[2:0];
            CSR_OFFSET_BITS: offset_bits = val;
            CSR_WAYS_IN_USE: ways_cfg    = val[3:0];
            default: ;
         endcase
      endfunction

      function int unsigned due_count();
         return outcomes_due.size();
      endfunction

      function logic [31:0] bump(logic [31:0] c);
         return (c == CNT_MAX) ? c : c + 32'd1;
      endfunction

      // ranks saturate at the oldest position
      function void age_line(int unsigned idx);
         if (line_rank[idx] < NUM_WAYS - 1)
            line_rank[idx] = line_rank[idx] + 3'd1;
      endfunction

      // look up one access, update the set and queue its outcome
      function void take_access(req_type r);
         int unsigned s, e, sh, base, w, hit_way, fill;
         logic [63:0] tg, st;
         logic [2:0]  hit_rank, oldest;
         bit          hit, empty_found;
         rsp_type     x;
         s  = (index_bits > MAX_SETB) ? MAX_SETB : index_bits;
         e  = (ways_cfg == 0) ? 1 : ((ways_cfg > NUM_WAYS) ? NUM_WAYS : ways_cfg);
         sh = s + offset_bits;
         tg = (sh >= 64) ? 64'd0 : (r.address >> sh);
         st = (r.address >> offset_bits) & ((64'd1 << s) - 64'd1);
         base = 32'(st) * NUM_WAYS;
         x = '0;

         // lowest matching way wins
         hit = 1'b0;
         hit_way = 0;
         for (w = 0; w < e; w++)
            if (!hit && line_ok[base + w] && line_tag[base + w] == tg) begin
               hit = 1'b1;
               hit_way = w;
            end

         if (hit) begin
            hit_rank = line_rank[base + hit_way];
            hits = bump(hits);
            for (w = 0; w < e; w++)
               if (w != hit_way && line_ok[base + w] && line_rank[base + w] < hit_rank)
                  age_line(base + w);
            line_rank[base + hit_way] = '0;
         end else begin
            misses = bump(misses);
            fill = 0;
            empty_found = 1'b0;
            for (w = 0; w < e; w++)
               if (!empty_found && !line_ok[base + w]) begin
                  fill = w;
                  empty_found = 1'b1;
               end
            // full set: evict the oldest, lowest way on a tie
            if (!empty_found) begin
               evictions = bump(evictions);
               x.was_eviction = 1'b1;
               oldest = '0;
               for (w = 0; w < e; w++)
                  if (w == 0 || line_rank[base + w] > oldest) begin
                     oldest = line_rank[base + w];
                     fill = w;
                  end
            end
            for (w = 0; w < e; w++)
               if (w != fill && line_ok[base + w])
                  age_line(base + w);
            line_ok[base + fill]   = 1'b1;
            line_tag[base + fill]  = tg;
            line_rank[base + fill] = '0;
         end

         // store half of a modify always hits
         if (r.command == CMD_MODIFY)
            hits = bump(hits);

         x.was_hit        = hit;
         x.was_miss       = !hit;
         x.modify_hit     = (r.command == CMD_MODIFY);
         x.hit_total      = hits;
         x.miss_total     = misses;
         x.eviction_total = evictions;
         outcomes_due.push_back(x);
      endfunction

      function void note_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      // compare a result beat with the oldest outcome due
      function void match_result(rsp_type got);
         rsp_type want;
         if (outcomes_due.size() == 0) begin
            mismatches++;
            $display("%0t: result beat with no access outstanding, expected none, got %h",
                     $time, got);
            return;
         end
         want = outcomes_due.pop_front();
         note_field("was_hit", want.was_hit, got.was_hit);
         note_field("was_miss", want.was_miss, got.was_miss);
         note_field("was_eviction", want.was_eviction, got.was_eviction);
         note_field("modify_hit", want.modify_hit, got.modify_hit);
         note_field("hit_total", want.hit_total, got.hit_total);
         note_field("miss_total", want.miss_total, got.miss_total);
         note_field("eviction_total", want.eviction_total, got.eviction_total);
      endfunction
   endclass

endpackage

@@ test/tb_set_assoc_cache_lru_tracker.sv @@
// testbench top: random and directed cache accesses checked against an lru predictor
`timescale 1ns / 1ps

module tb_set_assoc_cache_lru_tracker;
   import salru_pkg::*;
   import lru_outcome_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_CYCLES   = 80;
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 112;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [5:0]  csr_wdata = '0;

   // idle rates and long hold-off request
   int          send_idle_pct = 0;
   int          rcv_idle_pct = 0;
   logic        hold_req = 1'b0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   int          cycles = 0;

   // configuration as last written, for building addresses
   logic [2:0]  cur_index_bits = INDEX_BITS_RST;
   logic [5:0]  cur_offset_bits = OFFSET_BITS_RST;
   logic [3:0]  cur_ways = WAYS_IN_USE_RST;

   lru_outcome_tracker tracker = new();

   set_assoc_cache_lru_tracker dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #6 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result side: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_req && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   // watch both channels and the register port
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            tracker.match_result(rsp_payload);
         if (req_valid && !req_stall)
            tracker.take_access(req_payload);
         if (csr_wr_en)
            tracker.write_reg(csr_index, csr_wdata);
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int unsigned ways_used();
      return (cur_ways == 0) ? 1 : ((cur_ways > NUM_WAYS) ? NUM_WAYS : cur_ways);
   endfunction

   // place tag, set and offset where the current split puts them
   function automatic logic [63:0] compose_addr(logic [63:0] tg, logic [63:0] st,
                                                logic [63:0] off);
      int unsigned s, sh;
      logic [63:0] a;
      s  = (cur_index_bits > MAX_SETB) ? MAX_SETB : cur_index_bits;
      sh = s + cur_offset_bits;
      a  = off & ((64'd1 << cur_offset_bits) - 64'd1);
      a  = a | ((st & ((64'd1 << s) - 64'd1)) << cur_offset_bits);
      if (sh < 64)
         a = a | (tg << sh);
      return a;
   endfunction

   // offer one access beat and wait until it is taken
   task automatic send_access(logic [1:0] cmd, logic [63:0] addr);
      req_type beat;
      beat.command = cmd;
      beat.address = addr;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [5:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic set_geometry(logic [2:0] sb, logic [5:0] bb, logic [3:0] wu);
      write_csr(CSR_INDEX_BITS, {3'd0, sb});
      write_csr(CSR_OFFSET_BITS, bb);
      write_csr(CSR_WAYS_IN_USE, {2'd0, wu});
      csr_wr_en <= 1'b0;
      cur_index_bits  = sb;
      cur_offset_bits = bb;
      cur_ways        = wu;
   endtask

   // let every outstanding beat come back, then let the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.due_count() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly conflicting tags in a few sets, some scattered and raw addresses
   task automatic random_accesses(int count);
      int unsigned k, c;
      logic [63:0] addr;
      logic [1:0]  cmd;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(99);
         if (k < 55)
            addr = compose_addr(64'($urandom_range(0, ways_used() + 3)),
                                64'($urandom_range(0, 3)), rand64());
         else if (k < 80)
            addr = compose_addr(64'($urandom_range(0, 1023)), rand64(), rand64());
         else
            addr = rand64();
         c = $urandom_range(0, 9);
         cmd = (c < 3) ? CMD_LOAD : (c < 6) ? CMD_STORE : (c < 9) ? CMD_MODIFY : CMD_UNUSED;
         send_access(cmd, addr);
      end
   endtask

   initial begin
      logic [2:0] sb_list [8] = '{3'd0, 3'd7, 3'd6, 3'd3, 3'd2, 3'd6, 3'd1, 3'd5};
      logic [5:0] bb_list [8] = '{6'd0, 6'd63, 6'd32, 6'd6, 6'd0, 6'd0, 6'd33, 6'd12};
      logic [3:0] wu_list [8] = '{4'd1, 4'd0, 4'd15, 4'd4, 4'd8, 4'd2, 4'd9, 4'd8};

      send_idle_pct = 37;
      rcv_idle_pct <= 77;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // memory clearing sweep keeps the input stalled
      do @(posedge clock); while (req_stall);

      // directed: address extremes, every command, a full set and its eviction
      send_access(CMD_LOAD, 64'd0);
      send_access(CMD_STORE, 64'd0);
      send_access(CMD_MODIFY, '1);
      send_access(CMD_UNUSED, '1);
      send_access(CMD_STORE, 64'h8000_0000_0000_0000);
      for (int t = 1; t <= 8; t++)
         send_access(CMD_LOAD, compose_addr(64'(t), 64'd0, 64'(t)));
      send_access(CMD_MODIFY, compose_addr(64'd2, 64'd0, 64'd0));
      send_access(CMD_LOAD, compose_addr(64'd0, 64'd0, 64'd0));
      send_access(CMD_UNUSED, compose_addr(64'd5, 64'd0, 64'd15));
      drain();

      // unused register index must be ignored
      write_csr(CSR_UNUSED, '1);
      csr_wr_en <= 1'b0;

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph < 8)
            set_geometry(sb_list[ph], bb_list[ph], wu_list[ph]);
         else
            set_geometry(3'($urandom_range(0, 7)), 6'($urandom_range(0, 12)),
                         4'($urandom_range(0, 15)));
         if (ph < 4) begin
            send_idle_pct = 37;
            rcv_idle_pct <= 77;
         end else if (ph < 8) begin
            send_idle_pct = 77;
            rcv_idle_pct <= 37;
         end else begin
            send_idle_pct = 0;
            rcv_idle_pct <= 0;
         end
         // back up the whole pipe once with the sender running flat out
         if (ph == 9)
            hold_req <= 1'b1;
         random_accesses(PHASE_ITEMS);
         drain();
      end

      if (tracker.mismatches == 0 && tracker.due_count() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
